// File: sv/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  // Status codes carried with every result.
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Most result bytes that one input byte can cause.
  localparam int unsigned MAX_RES = 4;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_STR     = 3'd1,
    M_ESC     = 3'd2,
    M_HEX1    = 3'd3,
    M_WAIT_BS = 3'd4,
    M_WAIT_U  = 3'd5,
    M_HEX2    = 3'd6
  } mode_t;

  // Group of results produced by one input byte.
  typedef struct packed {
    logic [2:0]                 cnt;    // number of results, 1 to 4
    logic [MAX_RES-1:0][7:0]    bytes;  // bytes[0] goes out first
    logic                       dv;     // results carry decoded bytes
    logic [1:0]                 status;
  } res_t;

endpackage

// File: sv/jsu_decode.sv
// Escape decoder: parse state and the result group for the current byte.
module jsu_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_byte,
  input  logic          accept,
  output jsu_pkg::res_t res
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [5:0] HI_SUR   = 6'b110110;
  localparam logic [5:0] LO_SUR   = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  mode_t       mode_r, mode_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [9:0]  high_r, high_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic [3:0]  hex_d;
  logic        hex_ok;
  logic [15:0] hex_full;
  logic        quad_end;
  logic        hi_rng;
  logic        lo_rng;
  logic        esc_ok;
  logic [7:0]  esc_val;
  logic        err;
  logic [20:0] cp;
  logic        do_enc;

  // Hex digit value of the incoming byte.
  always_comb begin
    hex_d  = 4'd0;
    hex_ok = 1'b1;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_d = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_d = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_d = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_full = {hex_r[11:0], hex_d};
  assign quad_end = (cnt_r == 2'd3);
  assign hi_rng   = (hex_full[15:10] == HI_SUR);
  assign lo_rng   = (hex_full[15:10] == LO_SUR);

  // Single-byte escapes.
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = in_byte;
    case (in_byte)
      CH_QUOTE, CH_BSL, CH_SLASH: esc_val = in_byte;
      8'h62:   esc_val = 8'h08;
      8'h66:   esc_val = 8'h0c;
      8'h6e:   esc_val = 8'h0a;
      8'h72:   esc_val = 8'h0d;
      8'h74:   esc_val = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  // Syntax errors for every parse state.
  always_comb begin
    case (mode_r)
      M_IDLE:    err = 1'b0;
      M_STR:     err = (in_byte != CH_QUOTE) && (in_byte < CH_SPACE);
      M_ESC:     err = !esc_ok && (in_byte != CH_U);
      M_HEX1:    err = !hex_ok || (quad_end && lo_rng);
      M_HEX2:    err = !hex_ok || (quad_end && !lo_rng);
      M_WAIT_BS: err = (in_byte != CH_BSL);
      M_WAIT_U:  err = (in_byte != CH_U);
      default:   err = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    mode_nxt = mode_r;
    hex_nxt  = hex_r;
    high_nxt = high_r;
    cnt_nxt  = cnt_r;
    case (mode_r)
      M_IDLE: begin
        if (in_byte == CH_QUOTE) mode_nxt = M_STR;
      end
      M_STR: begin
        if (in_byte == CH_QUOTE) begin
          mode_nxt = M_IDLE;
        end else if (in_byte == CH_BSL) begin
          mode_nxt = M_ESC;
        end
      end
      M_ESC: begin
        if (esc_ok) begin
          mode_nxt = M_STR;
        end else if (in_byte == CH_U) begin
          hex_nxt  = 16'd0;
          cnt_nxt  = 2'd0;
          mode_nxt = M_HEX1;
        end
      end
      M_HEX1, M_HEX2: begin
        if (hex_ok) begin
          hex_nxt = hex_full;
          cnt_nxt = cnt_r + 2'd1;
          if (quad_end) begin
            if (mode_r == M_HEX1 && hi_rng) begin
              high_nxt = hex_full[9:0];
              mode_nxt = M_WAIT_BS;
            end else begin
              mode_nxt = M_STR;
            end
          end
        end
      end
      M_WAIT_BS: mode_nxt = M_WAIT_U;
      M_WAIT_U: begin
        hex_nxt  = 16'd0;
        cnt_nxt  = 2'd0;
        mode_nxt = M_HEX2;
      end
      default: mode_nxt = M_IDLE;
    endcase
    if (err) mode_nxt = M_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      hex_r  <= 16'd0;
      high_r <= 10'd0;
      cnt_r  <= 2'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      high_r <= high_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Code point of a completed quad, or of a completed surrogate pair.
  assign cp     = (mode_r == M_HEX2) ? SUPP_BASE + {1'b0, high_r, hex_full[9:0]}
                                     : {5'd0, hex_full};
  assign do_enc = quad_end && ((mode_r == M_HEX2) || (mode_r == M_HEX1 && !hi_rng));

  // Result group.
  always_comb begin
    res        = '0;
    res.cnt    = 3'd1;
    res.status = ST_RUN;
    if (err) begin
      res.status = ST_ERR;
    end else begin
      case (mode_r)
        M_STR: begin
          if (in_byte == CH_QUOTE) begin
            res.status = ST_DONE;
          end else if (in_byte != CH_BSL) begin
            res.dv       = 1'b1;
            res.bytes[0] = in_byte;
          end
        end
        M_ESC: begin
          if (esc_ok) begin
            res.dv       = 1'b1;
            res.bytes[0] = esc_val;
          end
        end
        M_HEX1, M_HEX2: begin
          if (do_enc) begin
            res.dv = 1'b1;
            if (cp <= 21'h7f) begin
              res.bytes[0] = cp[7:0];
            end else if (cp <= 21'h7ff) begin
              res.cnt      = 3'd2;
              res.bytes[0] = {3'b110, cp[10:6]};
              res.bytes[1] = {2'b10, cp[5:0]};
            end else if (cp <= 21'hffff) begin
              res.cnt      = 3'd3;
              res.bytes[0] = {4'b1110, cp[15:12]};
              res.bytes[1] = {2'b10, cp[11:6]};
              res.bytes[2] = {2'b10, cp[5:0]};
            end else begin
              res.cnt      = 3'd4;
              res.bytes[0] = {5'b11110, cp[20:18]};
              res.bytes[1] = {2'b10, cp[17:12]};
              res.bytes[2] = {2'b10, cp[11:6]};
              res.bytes[3] = {2'b10, cp[5:0]};
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: sv/json_string_unescape_utf8.sv
// The first result of an input byte is offered in the cycle after its transfer.
// Throughput: one input byte per cycle while each byte gives one result and out_tready
// is high; a byte that decodes to N UTF-8 bytes holds the result register until the
// single output port drains the result group, one byte a cycle while out_tready is high.
// Reset (synchronous, active low) returns the parser to idle and empties the output.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [0] out_valid, [2:1] status
  output logic       out_tlast
);
  import jsu_pkg::*;

  res_t       dec_res;
  res_t       res_r;
  logic       full_r;
  logic [1:0] idx_r;
  logic       in_xfer;
  logic       out_xfer;
  logic       at_last;

  assign at_last   = ({1'b0, idx_r} == (res_r.cnt - 3'd1));
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign in_tready = !full_r || (out_tready && at_last);

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_tdata),
    .accept  (in_xfer),
    .res     (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (in_xfer) begin
      full_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (out_xfer) begin
      if (at_last) begin
        full_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) res_r <= dec_res;
  end

  assign out_tvalid = full_r;
  assign out_tdata  = res_r.bytes[idx_r];
  assign out_tuser  = {res_r.status, res_r.dv};
  assign out_tlast  = at_last;

  // A new group only replaces one whose final byte leaves in the same cycle.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (!out_tvalid || (out_tready && out_tlast)))
    else $error("result group overwritten before it drained");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (res_r.cnt != 3'd0 && res_r.cnt <= 3'd4))
    else $error("result count out of range");

  // Completion and error reports never come with decoded data.
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && res_r.status != ST_RUN) |-> (res_r.cnt == 3'd1 && !res_r.dv))
    else $error("status report carries data");

  a_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 8'd0))
    else $error("nonzero byte on a result without data");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast && !in_tvalid) |=> !out_tvalid)
    else $error("output still valid after the final transfer");

endmodule
